FILE: rtl/keyed_debounce_timer_table_macros.svh
// assertion macros shared by the timer table rtl
`ifndef KEYED_DEBOUNCE_TIMER_TABLE_MACROS_SVH
`define KEYED_DEBOUNCE_TIMER_TABLE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define KDTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define KDTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/kdtt_pkg.sv
// types and constants of the keyed timer table
package kdtt_pkg;

  localparam int SLOTS  = 16;
  localparam int KEY_W  = 16;
  localparam int TIME_W = 16;

  localparam logic FUNC_SCHED = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // one timer entry as held by a cell
  typedef struct packed {
    logic              vld;
    logic              pend;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] rem;
  } ent_t;

  typedef enum logic [2:0] {
    OP_HOLD     = 3'd0,
    OP_SHR      = 3'd1,
    OP_SHL      = 3'd2,
    OP_SET      = 3'd3,
    OP_PEND     = 3'd4,
    OP_COLLAPSE = 3'd5
  } cell_op_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_t          op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] delay;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

FILE: rtl/kdtt_if.sv
// valid/ready channel interfaces for input and result items
interface kdtt_in_if import kdtt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [KEY_W-1:0]  task_id;
  logic [TIME_W-1:0] delay;
  logic [TIME_W-1:0] elapsed;

  modport source (output valid, func, task_id, delay, elapsed, input ready);
  modport sink   (input valid, func, task_id, delay, elapsed, output ready);
endinterface

interface kdtt_out_if import kdtt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic             fired;
  logic [KEY_W-1:0] fired_id;
  logic             last;

  modport source (output valid, status, fired, fired_id, last, input ready);
  modport sink   (input valid, status, fired, fired_id, last, output ready);
endinterface

FILE: rtl/kdtt_cell.sv
// one slot of the timer chain: holds an entry, trades it with its neighbors
module kdtt_cell import kdtt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  ent_t      left_in,
  input  ent_t      right_in,
  output ent_t      ent_o,
  output logic      match_o
);

  logic              vld_r, vld_nxt;
  logic              pend_r, pend_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [TIME_W-1:0] rem_r, rem_nxt;

  assign match_o = vld_r && (key_r == cmd.key);

  always_comb begin
    vld_nxt  = vld_r;
    pend_nxt = pend_r;
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    unique case (cmd.op)
      OP_HOLD: ;
      OP_SHR: begin
        vld_nxt  = left_in.vld;
        pend_nxt = left_in.pend;
        key_nxt  = left_in.key;
        rem_nxt  = left_in.rem;
      end
      OP_SHL: begin
        vld_nxt  = right_in.vld;
        pend_nxt = right_in.pend;
        key_nxt  = right_in.key;
        rem_nxt  = right_in.rem;
      end
      OP_SET: begin
        if (match_o) begin
          rem_nxt = cmd.delay;
        end
      end
      OP_PEND: pend_nxt = vld_r;
      OP_COLLAPSE: begin
        // only the unvisited part closes up; its last cell becomes a hole
        if (pend_r) begin
          if (right_in.pend) begin
            vld_nxt  = right_in.vld;
            pend_nxt = right_in.pend;
            key_nxt  = right_in.key;
            rem_nxt  = right_in.rem;
          end else begin
            vld_nxt  = 1'b0;
            pend_nxt = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    rem_r <= rem_nxt;
  end

  assign ent_o = '{vld: vld_r, pend: pend_r, key: key_r, rem: rem_r};

endmodule

FILE: rtl/keyed_debounce_timer_table.sv
// top level of the keyed one-shot timer table
//
//  channel   dir  fields                                handshake
//  in_ch     in   func, task_id, delay, elapsed         valid/ready
//  out_ch    out  status, fired, fired_id, last         valid/ready
//
// a schedule item: all cells compare the key at once, then either one cell
// reloads its time, the chain shifts toward the tail, or, when full, nothing moves.
// a tick marks every live entry pending, then walks the head: fired entries
// collapse out, survivors rotate to the tail, empty slots rotate out; the head
// cell is the only one examined, one entry per cycle unless a full result
// register stalls it, and fired ids leave at most one per cycle.
// synchronous active-low reset empties the table; key and time are not reset.
// a full result register stalls the walk; a new item is taken only when idle.
`include "keyed_debounce_timer_table_macros.svh"

module keyed_debounce_timer_table import kdtt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  kdtt_in_if.sink   in_ch,
  kdtt_out_if.source out_ch
);

  localparam logic [SLOTS-1:0] VEC_ONE = {{(SLOTS-1){1'b0}}, 1'b1};

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] el_r, el_nxt;
  logic              hold_v_r, hold_v_nxt;
  logic [KEY_W-1:0]  hold_id_r, hold_id_nxt;

  logic              out_v_r, out_v_nxt;
  logic              out_st_r, out_st_nxt;
  logic              out_fi_r, out_fi_nxt;
  logic [KEY_W-1:0]  out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t         cmd;
  ent_t              ent_arr   [SLOTS];
  ent_t              left_arr  [SLOTS];
  ent_t              right_arr [SLOTS];
  logic [SLOTS-1:0]  vld_vec, pend_vec, match_vec;
  ent_t              new_ent, tail_ent, head;

  logic in_acc, out_free, any_match, full, fire;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_v_r || out_ch.ready;
  assign head     = ent_arr[0];

  assign new_ent  = '{vld: 1'b1, pend: 1'b0, key: in_ch.task_id, rem: in_ch.delay};
  // head re-enters at the tail; an unvisited survivor takes off the elapsed time
  assign tail_ent = '{vld: head.vld, pend: 1'b0, key: head.key,
                      rem: head.pend ? (head.rem - el_r) : head.rem};

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      vld_vec[i]  = ent_arr[i].vld;
      pend_vec[i] = ent_arr[i].pend;
      left_arr[i]  = (i == 0) ? new_ent : ent_arr[(i == 0) ? 0 : i - 1];
      right_arr[i] = (i == SLOTS - 1) ? tail_ent : ent_arr[(i == SLOTS - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    kdtt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .left_in  (left_arr[g]),
      .right_in (right_arr[g]),
      .ent_o    (ent_arr[g]),
      .match_o  (match_vec[g])
    );
  end

  assign any_match = |match_vec;
  assign full      = vld_vec[SLOTS-1];
  assign fire      = head.pend && (head.rem <= el_r);

  always_comb begin
    state_nxt    = state_r;
    el_nxt       = el_r;
    hold_v_nxt   = hold_v_r;
    hold_id_nxt  = hold_id_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_st_nxt   = out_st_r;
    out_fi_nxt   = out_fi_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    cmd.op       = OP_HOLD;
    cmd.key      = in_ch.task_id;
    cmd.delay    = in_ch.delay;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == FUNC_TICK) begin
            cmd.op    = OP_PEND;
            el_nxt    = in_ch.elapsed;
            state_nxt = ST_TICK;
          end else begin
            if (any_match) begin
              cmd.op = OP_SET;
            end else if (!full) begin
              cmd.op = OP_SHR;
            end
            out_v_nxt    = 1'b1;
            out_st_nxt   = (!any_match && full) ? STATUS_FULL : STATUS_OK;
            out_fi_nxt   = 1'b0;
            out_id_nxt   = '0;
            out_last_nxt = 1'b1;
          end
        end
      end
      ST_TICK: begin
        if (head.pend) begin
          if (!fire) begin
            cmd.op = OP_SHL;
          end else if (!hold_v_r || out_free) begin
            // the previous fired id is known not to be last now
            cmd.op = OP_COLLAPSE;
            if (hold_v_r) begin
              out_v_nxt    = 1'b1;
              out_st_nxt   = STATUS_OK;
              out_fi_nxt   = 1'b1;
              out_id_nxt   = hold_id_r;
              out_last_nxt = 1'b0;
            end
            hold_v_nxt  = 1'b1;
            hold_id_nxt = head.key;
          end
        end else if (head.vld || !(|vld_vec)) begin
          state_nxt = ST_DONE;
        end else begin
          // rotate the empty slots out from in front of the survivors
          cmd.op = OP_SHL;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_v_nxt    = 1'b1;
          out_st_nxt   = STATUS_OK;
          out_fi_nxt   = hold_v_r;
          out_id_nxt   = hold_v_r ? hold_id_r : '0;
          out_last_nxt = 1'b1;
          hold_v_nxt   = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    el_r       <= el_nxt;
    hold_id_r  <= hold_id_nxt;
    out_st_r   <= out_st_nxt;
    out_fi_r   <= out_fi_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready     = (state_r == ST_IDLE) && out_free;
  assign out_ch.valid    = out_v_r;
  assign out_ch.status   = out_st_r;
  assign out_ch.fired    = out_fi_r;
  assign out_ch.fired_id = out_id_r;
  assign out_ch.last     = out_last_r;

  // between items the live entries sit packed from the head
  `KDTT_ASSERT_NOW(a_packed_idle, state_r == ST_IDLE,
    ((vld_vec + VEC_ONE) & vld_vec) == '0, "live entries not packed at head")
  `KDTT_ASSERT_NOW(a_no_pend_idle, state_r == ST_IDLE,
    pend_vec == '0 && !hold_v_r, "tick leftovers while idle")
  `KDTT_ASSERT_NEXT(a_tick_starts, in_acc && in_ch.func == FUNC_TICK,
    state_r == ST_TICK && pend_vec == $past(vld_vec), "tick did not mark entries")
  `KDTT_ASSERT_NOW(a_nofire_last, out_ch.valid && !out_ch.fired,
    out_ch.last && out_ch.fired_id == '0, "empty result must be last")

endmodule
